/* rtl/bts_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bts_pkg
// Shared item types, command codes and the sort microprogram of the
// bitonic sorter unit.
// ----------------------------------------------------------------------------
package bts_pkg;

    // fixed field widths
    localparam int WORD_W = 32;
    localparam int CFG_W  = 4;

    localparam logic [CFG_W-1:0] COUNT_LOG2_RESET = 4'd10;

    // command codes of an input item
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_READ = 1'b1;

    typedef struct packed {
        logic                     command;
        logic signed [WORD_W-1:0] value;
    } in_item_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] sorted_value;
        logic                     last_word;
        logic                     not_ready;
    } out_item_t;

    // microprogram addresses
    typedef logic [1:0] upc_t;

    localparam upc_t UC_RD   = 2'd0;
    localparam upc_t UC_CMP  = 2'd1;
    localparam upc_t UC_WR2  = 2'd2;
    localparam upc_t UC_STEP = 2'd3;

    // sequencing of one control word
    typedef enum logic [1:0] {
        JMP_NEXT,
        JMP_PAIRS,
        JMP_STEPS
    } jmp_t;

    typedef struct packed {
        logic rd_en;
        logic wr_lo;
        logic wr_hi;
        logic pair_inc;
        logic step_adv;
        jmp_t jmp;
        upc_t target;
    } ctl_t;

    localparam ctl_t CTL_IDLE = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, JMP_NEXT, UC_RD};

    // sort microprogram
    // rd: read the first pair of a step
    // cmp: compare, write lower address, move to next pair
    // wr2: write upper address, read the next pair, loop while pairs remain
    // step: advance step and stage, loop while the network is not finished
    function automatic ctl_t uc_rom(input upc_t pc);
        ctl_t w;
        w = CTL_IDLE;
        case (pc)
            UC_RD: begin
                w.rd_en = 1'b1;
                w.jmp   = JMP_NEXT;
            end
            UC_CMP: begin
                w.wr_lo    = 1'b1;
                w.pair_inc = 1'b1;
                w.jmp      = JMP_NEXT;
            end
            UC_WR2: begin
                w.wr_hi  = 1'b1;
                w.rd_en  = 1'b1;
                w.jmp    = JMP_PAIRS;
                w.target = UC_CMP;
            end
            UC_STEP: begin
                w.step_adv = 1'b1;
                w.jmp      = JMP_STEPS;
                w.target   = UC_RD;
            end
            default: begin
                w = CTL_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

/* rtl/bitonic_sorter_unit.sv */
`timescale 1ns / 1ps
// Load item: no result. Read item before the batch is sorted: a not-ready
// result is registered; once sorted, the word passes through the store read
// register and then the result register. Sort of N = 2^L words after the final
// load: L(L+1)/2 steps, two writes per pair through the single write port of
// the word store; no item is taken meanwhile.
// Reset (aresetn low, synchronous): empty batch, loading phase, count_log2 10.
// ----------------------------------------------------------------------------
// bitonic_sorter_unit
// Batch sorter: loads a power-of-two batch of signed words, sorts it with
// the bitonic compare-exchange network and returns the words in order.
// ----------------------------------------------------------------------------
module bitonic_sorter_unit #(
    parameter int MAX_WORDS = 1024
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  bts_pkg::in_item_t         s_item,
    output logic                      m_valid,
    input  logic                      m_ready,
    output bts_pkg::out_item_t        m_item,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [bts_pkg::CFG_W-1:0] cfg_data
);

    import bts_pkg::*;

    localparam int ADDR_W  = (MAX_WORDS > 2) ? $clog2(MAX_WORDS) : 1;
    localparam int LOG_MAX = $clog2(MAX_WORDS + 1) - 1;
    localparam int LG_W    = (LOG_MAX > 1) ? $clog2(LOG_MAX + 1) : 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SORT,
        ST_RDATA
    } state_t;

    state_t            state_reg;
    logic              m_valid_reg;
    out_item_t         m_item_reg;
    logic [CFG_W-1:0]  count_log2_reg;
    logic [ADDR_W-1:0] loaded_reg;
    logic [ADDR_W-1:0] rdpos_reg;
    logic              sorted_reg;
    logic              pend_last_reg;

    logic              s_fire;
    logic              cfg_fire;
    logic              load_ok;
    logic              fill;
    logic              read_ok;
    logic              read_last;
    logic [CFG_W:0]    lg_ext;
    logic [LG_W-1:0]   lgn;
    logic [ADDR_W-1:0] n_m1;

    ctl_t              ctl;
    logic [ADDR_W-1:0] seq_lo;
    logic [ADDR_W-1:0] seq_hi;
    logic              seq_desc;
    logic              seq_done;
    logic              cx_en;
    logic [ADDR_W-1:0] cx_addr;
    logic [WORD_W-1:0] cx_data;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    logic              ram0_re;
    logic [ADDR_W-1:0] ram0_raddr;
    logic [WORD_W-1:0] ram0_rdata;
    logic [WORD_W-1:0] ram1_rdata;

    // batch size, clamped to the supported range
    assign lg_ext = {1'b0, count_log2_reg};
    always_comb begin
        if (lg_ext == '0) begin
            lgn = LG_W'(1);
        end else if (lg_ext > (CFG_W + 1)'(LOG_MAX)) begin
            lgn = LG_W'(LOG_MAX);
        end else begin
            lgn = LG_W'(lg_ext);
        end
    end
    assign n_m1 = ~({ADDR_W{1'b1}} << lgn);

    // handshakes
    assign s_ready   = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign cfg_ready = (state_reg == ST_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign m_valid   = m_valid_reg;
    assign m_item    = m_item_reg;

    // item decode
    assign load_ok   = s_fire && (s_item.command == CMD_LOAD) && !sorted_reg;
    assign fill      = load_ok && (loaded_reg == n_m1);
    assign read_ok   = sorted_reg;
    assign read_last = (rdpos_reg == n_m1);

    // sort sequencer
    bts_seq #(
        .ADDR_W (ADDR_W),
        .LG_W   (LG_W)
    ) u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (fill),
        .lgn     (lgn),
        .ctl     (ctl),
        .addr_lo (seq_lo),
        .addr_hi (seq_hi),
        .desc    (seq_desc),
        .done    (seq_done)
    );

    // compare-exchange datapath
    bts_cmpx #(
        .ADDR_W (ADDR_W)
    ) u_cmpx (
        .aclk    (aclk),
        .ctl     (ctl),
        .addr_lo (seq_lo),
        .addr_hi (seq_hi),
        .desc    (seq_desc),
        .rd_lo   (ram0_rdata),
        .rd_hi   (ram1_rdata),
        .wr_en   (cx_en),
        .wr_addr (cx_addr),
        .wr_data (cx_data)
    );

    // store write port: loads or sort write-back
    assign ram_we    = load_ok || cx_en;
    assign ram_waddr = load_ok ? loaded_reg : cx_addr;
    assign ram_wdata = load_ok ? s_item.value : cx_data;

    // lower read port also serves result reads
    assign ram0_re    = (state_reg == ST_SORT) ? ctl.rd_en
                                               : (s_fire && (s_item.command == CMD_READ));
    assign ram0_raddr = (state_reg == ST_SORT) ? seq_lo : rdpos_reg;

    // two copies of the store give two read ports
    bts_ram #(
        .DATA_W (WORD_W),
        .DEPTH  (MAX_WORDS),
        .ADDR_W (ADDR_W)
    ) u_store_lo (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram0_re),
        .raddr (ram0_raddr),
        .rdata (ram0_rdata)
    );

    bts_ram #(
        .DATA_W (WORD_W),
        .DEPTH  (MAX_WORDS),
        .ADDR_W (ADDR_W)
    ) u_store_hi (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ctl.rd_en),
        .raddr (seq_hi),
        .rdata (ram1_rdata)
    );

    // batch control and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            m_valid_reg    <= 1'b0;
            count_log2_reg <= COUNT_LOG2_RESET;
            loaded_reg     <= '0;
            rdpos_reg      <= '0;
            sorted_reg     <= 1'b0;
            pend_last_reg  <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_fire) begin
                        if (s_item.command == CMD_LOAD) begin
                            if (load_ok) begin
                                loaded_reg <= loaded_reg + ADDR_W'(1);
                                if (fill) begin
                                    loaded_reg <= '0;
                                    state_reg  <= ST_SORT;
                                end
                            end
                        end else if (read_ok) begin
                            pend_last_reg <= read_last;
                            rdpos_reg     <= read_last ? '0 : rdpos_reg + ADDR_W'(1);
                            if (read_last) begin
                                sorted_reg <= 1'b0;
                            end
                            state_reg <= ST_RDATA;
                        end else begin
                            m_valid_reg             <= 1'b1;
                            m_item_reg.sorted_value <= '0;
                            m_item_reg.last_word    <= 1'b0;
                            m_item_reg.not_ready    <= 1'b1;
                        end
                    end
                    if (cfg_fire) begin
                        count_log2_reg <= cfg_data;
                        loaded_reg     <= '0;
                        rdpos_reg      <= '0;
                        sorted_reg     <= 1'b0;
                    end
                end
                ST_SORT: begin
                    if (seq_done) begin
                        sorted_reg <= 1'b1;
                        rdpos_reg  <= '0;
                        state_reg  <= ST_IDLE;
                    end
                end
                ST_RDATA: begin
                    m_valid_reg             <= 1'b1;
                    m_item_reg.sorted_value <= ram0_rdata;
                    m_item_reg.last_word    <= pend_last_reg;
                    m_item_reg.not_ready    <= 1'b0;
                    state_reg               <= ST_IDLE;
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

/* rtl/bts_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bts_ram
// Generic single write, single read memory with registered read data.
// ----------------------------------------------------------------------------
module bts_ram #(
    parameter int DATA_W = 32,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/bts_seq.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bts_seq
// Microcoded sequencer of the bitonic network: program counter, control
// word table, stage, step and pair counters, and pair address generation.
// ----------------------------------------------------------------------------
module bts_seq #(
    parameter int ADDR_W = 10,
    parameter int LG_W   = 4
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [LG_W-1:0]   lgn,
    output bts_pkg::ctl_t     ctl,
    output logic [ADDR_W-1:0] addr_lo,
    output logic [ADDR_W-1:0] addr_hi,
    output logic              desc,
    output logic              done
);

    import bts_pkg::*;

    localparam int PAIR_W = (ADDR_W > 1) ? ADDR_W - 1 : 1;

    logic              run_reg;
    upc_t              pc_reg;
    upc_t              pc_next;
    logic [LG_W-1:0]   klog_reg;
    logic [LG_W-1:0]   jlog_reg;
    logic [PAIR_W-1:0] pair_reg;
    logic [PAIR_W-1:0] pair_last;
    logic              more_pairs;
    logic              more_steps;
    logic [ADDR_W-1:0] pair_ext;
    logic [ADDR_W-1:0] low_mask;
    logic [ADDR_W-1:0] lo_addr;
    logic [ADDR_W-1:0] stage_bits;

    // control word of the current step
    assign ctl = run_reg ? uc_rom(pc_reg) : CTL_IDLE;

    // loop conditions
    assign pair_last  = ~({PAIR_W{1'b1}} << (lgn - LG_W'(1)));
    assign more_pairs = (pair_reg != '0);
    assign more_steps = !((klog_reg == lgn) && (jlog_reg == '0));

    always_comb begin
        pc_next = pc_reg + upc_t'(1);
        case (ctl.jmp)
            JMP_NEXT:  pc_next = pc_reg + upc_t'(1);
            JMP_PAIRS: pc_next = more_pairs ? ctl.target : pc_reg + upc_t'(1);
            JMP_STEPS: pc_next = ctl.target;
            default:   pc_next = pc_reg + upc_t'(1);
        endcase
    end

    assign done = run_reg && (ctl.jmp == JMP_STEPS) && !more_steps;

    // pair addresses: a zero bit is inserted at the step position
    assign pair_ext   = ADDR_W'(pair_reg);
    assign low_mask   = ~({ADDR_W{1'b1}} << jlog_reg);
    assign lo_addr    = ((pair_ext & ~low_mask) << 1) | (pair_ext & low_mask);
    assign addr_lo    = lo_addr;
    assign addr_hi    = lo_addr | (ADDR_W'(1) << jlog_reg);
    assign stage_bits = lo_addr >> klog_reg;
    assign desc       = stage_bits[0];

    // program counter and loop counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            pc_reg   <= UC_RD;
            klog_reg <= LG_W'(1);
            jlog_reg <= '0;
            pair_reg <= '0;
        end else if (start) begin
            run_reg  <= 1'b1;
            pc_reg   <= UC_RD;
            klog_reg <= LG_W'(1);
            jlog_reg <= '0;
            pair_reg <= '0;
        end else if (run_reg) begin
            pc_reg <= pc_next;
            if (ctl.pair_inc) begin
                pair_reg <= (pair_reg == pair_last) ? '0 : pair_reg + PAIR_W'(1);
            end
            if (ctl.step_adv) begin
                if (jlog_reg == '0) begin
                    klog_reg <= klog_reg + LG_W'(1);
                    jlog_reg <= klog_reg;
                end else begin
                    jlog_reg <= jlog_reg - LG_W'(1);
                end
            end
            if (done) begin
                run_reg <= 1'b0;
            end
        end
    end

endmodule

/* rtl/bts_cmpx.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bts_cmpx
// Compare-exchange datapath: orders one pair of words and writes it back
// through the single write port of the store, lower word first.
// ----------------------------------------------------------------------------
module bts_cmpx #(
    parameter int ADDR_W = 10
) (
    input  logic                        aclk,
    input  bts_pkg::ctl_t               ctl,
    input  logic [ADDR_W-1:0]           addr_lo,
    input  logic [ADDR_W-1:0]           addr_hi,
    input  logic                        desc,
    input  logic [bts_pkg::WORD_W-1:0]  rd_lo,
    input  logic [bts_pkg::WORD_W-1:0]  rd_hi,
    output logic                        wr_en,
    output logic [ADDR_W-1:0]           wr_addr,
    output logic [bts_pkg::WORD_W-1:0]  wr_data
);

    import bts_pkg::*;

    logic              swap;
    logic [ADDR_W-1:0] hi_addr_reg;
    logic [WORD_W-1:0] hi_data_reg;

    // ascending pairs swap when lower is greater, descending the other way
    assign swap = desc ? ($signed(rd_hi) > $signed(rd_lo))
                       : ($signed(rd_lo) > $signed(rd_hi));

    // hold the upper half of the pair for the second write
    always_ff @(posedge aclk) begin
        if (ctl.wr_lo) begin
            hi_addr_reg <= addr_hi;
            hi_data_reg <= swap ? rd_lo : rd_hi;
        end
    end

    // write port request
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = addr_lo;
        wr_data = swap ? rd_hi : rd_lo;
        if (ctl.wr_lo) begin
            wr_en = 1'b1;
        end else if (ctl.wr_hi) begin
            wr_en   = 1'b1;
            wr_addr = hi_addr_reg;
            wr_data = hi_data_reg;
        end
    end

endmodule
